// ===== rtl/axis_vector_rotator_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the axis vector rotator
// Both macros use the clk and rst of the module that includes this header.
// ----------------------------------------------------------------------------
`ifndef AXIS_VECTOR_ROTATOR_MACROS_SVH
`define AXIS_VECTOR_ROTATOR_MACROS_SVH

// same-cycle implication
`define AVR_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define AVR_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/avr_pkg.sv =====
// ----------------------------------------------------------------------------
// avr_pkg
// Word types and constants of the axis vector rotator.
// ----------------------------------------------------------------------------
package avr_pkg;

  typedef struct packed {
    logic signed [31:0] in_x;
    logic signed [31:0] in_y;
    logic signed [31:0] in_z;
    logic [31:0]        turn_angle;
    logic [1:0]         axis_select;
  } vec_word_t;

  typedef struct packed {
    logic signed [31:0] out_x;
    logic signed [31:0] out_y;
    logic signed [31:0] out_z;
  } rot_word_t;

  // components, axis and fold flag travelling along the pipeline
  typedef struct packed {
    logic signed [31:0] c0;
    logic signed [31:0] c1;
    logic signed [31:0] c2;
    logic [1:0]         axis;
    logic               flip;
  } carry_t;

  localparam logic [1:0] AXIS_X = 2'd0;
  localparam logic [1:0] AXIS_Y = 2'd1;
  localparam logic [1:0] AXIS_Z = 2'd2;

  localparam logic signed [31:0] COEF_ONE = 32'sd1073741824;
  localparam logic [47:0]        GAIN_Q46 = 48'd42731626434776;

  localparam int ATAN_LEN = 48;

  // atan(2^-i) in units of 2^-32 turn
  localparam logic [29:0] ATAN_TURNS [0:ATAN_LEN-1] = '{
    30'd536870912, 30'd316933406, 30'd167458907, 30'd85004756,
    30'd42667331,  30'd21354465,  30'd10679838,  30'd5340245,
    30'd2670163,   30'd1335087,   30'd667544,    30'd333772,
    30'd166886,    30'd83443,     30'd41722,     30'd20861,
    30'd10430,     30'd5215,      30'd2608,      30'd1304,
    30'd652,       30'd326,       30'd163,       30'd81,
    30'd41,        30'd20,        30'd10,        30'd5,
    30'd3,         30'd1,         30'd1,         30'd0,
    30'd0,         30'd0,         30'd0,         30'd0,
    30'd0,         30'd0,         30'd0,         30'd0,
    30'd0,         30'd0,         30'd0,         30'd0,
    30'd0,         30'd0,         30'd0,         30'd0
  };

endpackage

// ===== rtl/axis_vector_rotator.sv =====
// Throughput: one word per cycle while vec_stall is low; one CORDIC iteration per pipeline stage.
// A two-entry output (register plus skid) takes one word past an output stall;
// then the pipeline and the input stall. Reset clears all valid bits only.
// ----------------------------------------------------------------------------
// axis_vector_rotator
// Rotates a Q1.30 vector about the x, y or z axis by a binary angle, with
// sine and cosine from a pipelined gain-compensated CORDIC.
// ----------------------------------------------------------------------------
`include "axis_vector_rotator_macros.svh"

module axis_vector_rotator #(
  parameter int DATA_WIDTH    = 32,
  parameter int CORDIC_STAGES = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               vec_valid,
  output logic               vec_stall,
  input  avr_pkg::vec_word_t vec_word,
  output logic               rot_valid,
  input  logic               rot_stall,
  output avr_pkg::rot_word_t rot_word
);

  localparam int W      = DATA_WIDTH + 2;
  localparam int N      = CORDIC_STAGES;
  localparam int ZW     = 34;
  localparam int ST_RND = N + 1;
  localparam int ST_MUL = N + 2;
  localparam int DEPTH  = N + 3;
  localparam int TW     = (DATA_WIDTH > 32) ? W + 1 : 34;

  localparam int          GSHIFT    = 48 - DATA_WIDTH;
  localparam logic [47:0] GAIN_HALF = (48'd1 << GSHIFT) >> 1;
  localparam logic [47:0] GAIN_X0   = (avr_pkg::GAIN_Q46 + GAIN_HALF) >> GSHIFT;

  localparam logic signed [TW-1:0] C_ONE    = TW'(avr_pkg::COEF_ONE);
  localparam logic signed [63:0]   RND_HALF = 64'sd536870912;

  function automatic logic signed [31:0] finish_q30(input logic signed [63:0] acc);
    logic signed [63:0] r;
    r = (acc + RND_HALF) >>> 30;
    if (r > 64'sd2147483647) begin
      return 32'sh7fffffff;
    end else if (r < -64'sd2147483648) begin
      return 32'sh80000000;
    end
    return 32'(r);
  endfunction

  function automatic logic signed [31:0] clamp_q30(input logic signed [TW-1:0] v,
                                                   input logic flip);
    logic signed [31:0] c;
    if (v > C_ONE) begin
      c = avr_pkg::COEF_ONE;
    end else if (v < -C_ONE) begin
      c = -avr_pkg::COEF_ONE;
    end else begin
      c = 32'(v);
    end
    return flip ? -c : c;
  endfunction

  // pipeline control
  logic [DEPTH-1:0] vld;
  logic             pipe_en;
  logic             skid_vld;
  logic             out_free;

  assign pipe_en   = !skid_vld;
  assign vec_stall = skid_vld;
  assign out_free  = !rot_valid || !rot_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (pipe_en) begin
      vld <= {vld[DEPTH-2:0], vec_valid};
    end
  end

  // input stage: quadrant fold
  logic signed [W-1:0]  cx [0:N];
  logic signed [W-1:0]  cy [0:N];
  logic signed [ZW-1:0] cz [0:N];
  avr_pkg::carry_t      car [0:N];
  logic                 flip_in;
  logic [31:0]          ang_fold;

  assign flip_in  = vec_word.turn_angle[31] ^ vec_word.turn_angle[30];
  assign ang_fold = {vec_word.turn_angle[31] ^ flip_in, vec_word.turn_angle[30:0]};

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      cx[0]  <= W'(GAIN_X0);
      cy[0]  <= '0;
      cz[0]  <= ZW'($signed(ang_fold));
      car[0] <= '{c0: vec_word.in_x, c1: vec_word.in_y, c2: vec_word.in_z,
                  axis: vec_word.axis_select, flip: flip_in};
    end
  end

  // CORDIC iterations, one per stage
  for (genvar i = 0; i < N; i++) begin : g_cordic
    localparam logic signed [ZW-1:0] T_I = $signed(ZW'(avr_pkg::ATAN_TURNS[i]));

    always_ff @(posedge clk) begin
      if (pipe_en) begin
        if (!cz[i][ZW-1]) begin
          cx[i+1] <= cx[i] - (cy[i] >>> i);
          cy[i+1] <= cy[i] + (cx[i] >>> i);
          cz[i+1] <= cz[i] - T_I;
        end else begin
          cx[i+1] <= cx[i] + (cy[i] >>> i);
          cy[i+1] <= cy[i] - (cx[i] >>> i);
          cz[i+1] <= cz[i] + T_I;
        end
        car[i+1] <= car[i];
      end
    end
  end

  // coefficient rounding (or left scaling) to Q30
  logic signed [TW-1:0] rnd_c;
  logic signed [TW-1:0] rnd_s;

  if (DATA_WIDTH > 32) begin : g_round
    localparam int                  SH   = DATA_WIDTH - 32;
    localparam logic signed [TW-1:0] HALF = TW'(1) <<< (SH - 1);
    assign rnd_c = (TW'(cx[N]) + HALF) >>> SH;
    assign rnd_s = (TW'(cy[N]) + HALF) >>> SH;
  end else begin : g_scale
    localparam int SH = 32 - DATA_WIDTH;
    assign rnd_c = TW'(cx[N]) <<< SH;
    assign rnd_s = TW'(cy[N]) <<< SH;
  end

  logic signed [31:0] coef_c;
  logic signed [31:0] coef_s;
  logic signed [31:0] opa;
  logic signed [31:0] opb;
  logic signed [31:0] opa_next;
  logic signed [31:0] opb_next;
  avr_pkg::carry_t    car_r;
  logic               coef_ok;

  always_comb begin
    case (car[N].axis)
      avr_pkg::AXIS_X: begin
        opa_next = car[N].c1;
        opb_next = car[N].c2;
      end
      avr_pkg::AXIS_Y: begin
        opa_next = car[N].c2;
        opb_next = car[N].c0;
      end
      avr_pkg::AXIS_Z: begin
        opa_next = car[N].c0;
        opb_next = car[N].c1;
      end
      default: begin
        opa_next = car[N].c0;
        opb_next = car[N].c1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      coef_c <= clamp_q30(rnd_c, car[N].flip);
      coef_s <= clamp_q30(rnd_s, car[N].flip);
      opa    <= opa_next;
      opb    <= opb_next;
      car_r  <= car[N];
    end
  end

  assign coef_ok = (coef_c <= avr_pkg::COEF_ONE) && (coef_c >= -avr_pkg::COEF_ONE) &&
                   (coef_s <= avr_pkg::COEF_ONE) && (coef_s >= -avr_pkg::COEF_ONE);

  // products
  logic signed [63:0] prod_ac;
  logic signed [63:0] prod_bs;
  logic signed [63:0] prod_bc;
  logic signed [63:0] prod_as;
  avr_pkg::carry_t    car_m;

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      prod_ac <= 64'(opa) * 64'(coef_c);
      prod_bs <= 64'(opb) * 64'(coef_s);
      prod_bc <= 64'(opb) * 64'(coef_c);
      prod_as <= 64'(opa) * 64'(coef_s);
      car_m   <= car_r;
    end
  end

  // final sum, round, saturate and placement
  logic signed [31:0] new_a;
  logic signed [31:0] new_b;
  avr_pkg::rot_word_t fin_word;
  avr_pkg::rot_word_t skid_word;

  assign new_a = finish_q30(prod_ac - prod_bs);
  assign new_b = finish_q30(prod_bc + prod_as);

  always_comb begin
    fin_word = '{out_x: car_m.c0, out_y: car_m.c1, out_z: car_m.c2};
    case (car_m.axis)
      avr_pkg::AXIS_X: begin
        fin_word.out_y = new_a;
        fin_word.out_z = new_b;
      end
      avr_pkg::AXIS_Y: begin
        fin_word.out_z = new_a;
        fin_word.out_x = new_b;
      end
      avr_pkg::AXIS_Z: begin
        fin_word.out_x = new_a;
        fin_word.out_y = new_b;
      end
      default: begin
        fin_word.out_x = car_m.c0;
      end
    endcase
  end

  // output register with skid entry
  always_ff @(posedge clk) begin
    if (rst) begin
      rot_valid <= 1'b0;
      skid_vld  <= 1'b0;
    end else if (skid_vld) begin
      if (out_free) begin
        rot_valid <= 1'b1;
        skid_vld  <= 1'b0;
      end
    end else if (vld[DEPTH-1]) begin
      if (out_free) begin
        rot_valid <= 1'b1;
      end else begin
        skid_vld <= 1'b1;
      end
    end else if (out_free) begin
      rot_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_vld) begin
      if (out_free) begin
        rot_word <= skid_word;
      end
    end else if (vld[DEPTH-1]) begin
      if (out_free) begin
        rot_word <= fin_word;
      end else begin
        skid_word <= fin_word;
      end
    end
  end

  `AVR_ASSERT_IMP(a_skid_needs_out, skid_vld, rot_valid, "skid full while output empty")
  `AVR_ASSERT_NXT(a_skid_drains, skid_vld && !rot_stall, !skid_vld, "skid did not drain")
  `AVR_ASSERT_IMP(a_coef_range, vld[ST_RND], coef_ok, "coefficient out of range")
  `AVR_ASSERT_NXT(a_mul_follows, pipe_en && vld[ST_RND], vld[ST_MUL], "product stage lost a word")

endmodule
